// ----- design/mvt_pkg.sv -----
package mvt_pkg;

  localparam int unsigned NUM_REGS  = 8;
  localparam int unsigned CFG_IDX_W = 4;
  localparam int unsigned CFG_DATA_W = 64;
  localparam int unsigned DIM       = 4;

  typedef logic signed [31:0] elem_t;
  typedef elem_t [DIM-1:0] vec_t;
  typedef vec_t  [DIM-1:0] mat_t;

  typedef logic signed [63:0] prod_t;
  typedef prod_t [DIM-1:0] prow_t;
  typedef prow_t [DIM-1:0] pmat_t;

  // pair sums and row sums of four 64-bit products, exact
  typedef logic signed [64:0] psum_t;
  typedef psum_t [1:0] prow_sum_t;
  typedef prow_sum_t [DIM-1:0] pmat_sum_t;

  typedef logic signed [65:0] sum_t;
  typedef sum_t [DIM-1:0] sum_vec_t;

  // identity matrix in Q16.16, register 7 first
  localparam logic [NUM_REGS-1:0][CFG_DATA_W-1:0] CFG_RESET = {
    64'h0001_0000_0000_0000, 64'h0000_0000_0000_0000,
    64'h0000_0000_0001_0000, 64'h0000_0000_0000_0000,
    64'h0000_0000_0000_0000, 64'h0001_0000_0000_0000,
    64'h0000_0000_0000_0000, 64'h0000_0000_0001_0000
  };

endpackage

// ----- design/mvt_mul.sv -----
module mvt_mul (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  mvt_pkg::mat_t mat,
  input  mvt_pkg::vec_t vec,
  output logic          out_valid,
  input  logic          out_ready,
  output mvt_pkg::pmat_t prod
);

  logic           valid_r;
  mvt_pkg::pmat_t prod_r;
  mvt_pkg::pmat_t prod_nxt;

  assign in_ready = !valid_r || out_ready;

  // sixteen independent 32x32 signed products
  always_comb begin
    for (int r = 0; r < mvt_pkg::DIM; r++) begin
      for (int c = 0; c < mvt_pkg::DIM; c++) begin
        prod_nxt[r][c] = mat[r][c] * vec[c];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      prod_r <= prod_nxt;
    end
  end

  assign out_valid = valid_r;
  assign prod      = prod_r;

endmodule

// ----- design/mvt_add_tree.sv -----
module mvt_add_tree (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  mvt_pkg::pmat_t    prod,
  output logic              out_valid,
  input  logic              out_ready,
  output mvt_pkg::sum_vec_t sum
);

  logic                 pair_valid_r;
  logic                 pair_ready;
  mvt_pkg::pmat_sum_t   pair_r;
  mvt_pkg::pmat_sum_t   pair_nxt;
  logic                 sum_valid_r;
  mvt_pkg::sum_vec_t    sum_r;
  mvt_pkg::sum_vec_t    sum_nxt;

  assign pair_ready = !sum_valid_r || out_ready;
  assign in_ready   = !pair_valid_r || pair_ready;

  // first level: columns 0+1 and 2+3
  always_comb begin
    for (int r = 0; r < mvt_pkg::DIM; r++) begin
      pair_nxt[r][0] = mvt_pkg::psum_t'(prod[r][0]) + mvt_pkg::psum_t'(prod[r][1]);
      pair_nxt[r][1] = mvt_pkg::psum_t'(prod[r][2]) + mvt_pkg::psum_t'(prod[r][3]);
    end
  end

  // second level: full row sum
  always_comb begin
    for (int r = 0; r < mvt_pkg::DIM; r++) begin
      sum_nxt[r] = mvt_pkg::sum_t'(pair_r[r][0]) + mvt_pkg::sum_t'(pair_r[r][1]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pair_valid_r <= 1'b0;
      sum_valid_r  <= 1'b0;
    end else begin
      if (in_ready) begin
        pair_valid_r <= in_valid;
      end
      if (pair_ready) begin
        sum_valid_r <= pair_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      pair_r <= pair_nxt;
    end
    if (pair_ready && pair_valid_r) begin
      sum_r <= sum_nxt;
    end
  end

  assign out_valid = sum_valid_r;
  assign sum       = sum_r;

endmodule

// ----- design/mvt_sat.sv -----
module mvt_sat #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  mvt_pkg::sum_vec_t sum,
  output logic              out_valid,
  input  logic              out_ready,
  output mvt_pkg::vec_t     res,
  output logic              sat
);

  logic              valid_r;
  mvt_pkg::vec_t     res_r;
  mvt_pkg::vec_t     res_nxt;
  logic              sat_r;
  logic              sat_nxt;
  mvt_pkg::sum_vec_t shifted;
  logic [mvt_pkg::DIM-1:0] clip;

  assign in_ready = !valid_r || out_ready;

  // arithmetic shift rounds toward minus infinity, then clip to 32 bits
  always_comb begin
    for (int r = 0; r < mvt_pkg::DIM; r++) begin
      shifted[r] = sum[r] >>> FRAC_BITS;
      clip[r]    = !((&shifted[r][65:31]) || !(|shifted[r][65:31]));
      if (clip[r]) begin
        res_nxt[r] = shifted[r][65] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      end else begin
        res_nxt[r] = shifted[r][31:0];
      end
    end
    sat_nxt = |clip;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      res_r <= res_nxt;
      sat_r <= sat_nxt;
    end
  end

  assign out_valid = valid_r;
  assign res       = res_r;
  assign sat       = sat_r;

endmodule

// ----- design/matrix4_vector_transform.sv -----
// 4x4 matrix times 4-vector, signed q16.16 in and out
// config: cfg_we writes cfg_data into register cfg_index at the clock edge,
//   no wait states; indexes 0..7 hold rows 0..3, two elements each
//   (low 32 bits = even column, high 32 bits = odd column); 8..15 ignored
// input word: in_x..in_w, taken when in_valid and in_ready are both high
// output word: out_x..out_w plus out_saturated, handed over on
//   out_valid and out_ready
// pipeline: out_valid rises once an accepted input word has passed four
//   register stages (multiply, pair add, row add, shift and clip)
// throughput: one word per cycle while out_ready is not held low, set by
//   the four-stage pipeline with sixteen 32x32 multipliers in its first stage
// each stage has its own valid bit and stalls only when the stage after it
//   is full and blocked, so bubbles collapse and a waiting result does not
//   stop new words from entering the free stages
// a stalled receiver holds out_* stable; nothing is dropped or repeated
// reset (rst_n low, synchronous) empties the pipeline and loads the
//   identity matrix
module matrix4_vector_transform #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // configuration
  input  logic                             cfg_we,
  input  logic [mvt_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [mvt_pkg::CFG_DATA_W-1:0]   cfg_data,
  // input words
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic signed [31:0]               in_x,
  input  logic signed [31:0]               in_y,
  input  logic signed [31:0]               in_z,
  input  logic signed [31:0]               in_w,
  // result words
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic signed [31:0]               out_x,
  output logic signed [31:0]               out_y,
  output logic signed [31:0]               out_z,
  output logic signed [31:0]               out_w,
  output logic                             out_saturated
);

  // matrix registers, two elements per register
  logic [mvt_pkg::NUM_REGS-1:0][mvt_pkg::CFG_DATA_W-1:0] cfg_r;

  mvt_pkg::mat_t     mat;
  mvt_pkg::vec_t     vec;
  mvt_pkg::pmat_t    prod;
  mvt_pkg::sum_vec_t sum;
  mvt_pkg::vec_t     res;

  logic mul_valid;
  logic add_ready;
  logic add_valid;
  logic sat_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= mvt_pkg::CFG_RESET;
    end else if (cfg_we && (cfg_index < mvt_pkg::CFG_IDX_W'(mvt_pkg::NUM_REGS))) begin
      cfg_r[cfg_index[2:0]] <= cfg_data;
    end
  end

  // unpack registers into elements
  always_comb begin
    for (int r = 0; r < mvt_pkg::DIM; r++) begin
      for (int c = 0; c < mvt_pkg::DIM; c++) begin
        mat[r][c] = cfg_r[2*r + (c >> 1)][32*(c & 1) +: 32];
      end
    end
  end

  assign vec[0] = in_x;
  assign vec[1] = in_y;
  assign vec[2] = in_z;
  assign vec[3] = in_w;

  // stage 1: products
  mvt_mul u_mul (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .mat       (mat),
    .vec       (vec),
    .out_valid (mul_valid),
    .out_ready (add_ready),
    .prod      (prod)
  );

  // stages 2 and 3: exact row sums
  mvt_add_tree u_add (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (mul_valid),
    .in_ready  (add_ready),
    .prod      (prod),
    .out_valid (add_valid),
    .out_ready (sat_ready),
    .sum       (sum)
  );

  // stage 4: scale back and clip, also the output register
  mvt_sat #(
    .FRAC_BITS (FRAC_BITS)
  ) u_sat (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (add_valid),
    .in_ready  (sat_ready),
    .sum       (sum),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .res       (res),
    .sat       (out_saturated)
  );

  assign out_x = res[0];
  assign out_y = res[1];
  assign out_z = res[2];
  assign out_w = res[3];

endmodule
